[hw/rtl/vdu_pkg.sv]
// ----------------------------------------------------------------------------
// vdu_pkg
// Shared types and constants of the vector distance unit.
// ----------------------------------------------------------------------------
package vdu_pkg;

  localparam int MaxDim = 1024;

  localparam logic [1:0] METRIC_L2  = 2'd0;
  localparam logic [1:0] METRIC_IP  = 2'd1;
  localparam logic [1:0] METRIC_COS = 2'd2;

  localparam logic REG_METRIC = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  localparam logic signed [27:0] DIST_MAX = 28'sh7FFFFFF;
  localparam logic signed [27:0] DIST_MIN = -28'sh8000000;

  // controller to datapath commands
  typedef struct packed {
    logic acc_en;      // accumulate the input item
    logic acc_clear;   // clear accumulators
    logic root_start;  // load the root unit; sel picks the operand
    logic [1:0] root_sel;  // 0 diff sum, 1 first norm, 2 second norm
    logic root_save_x;     // keep root as first norm
    logic mul_en;      // form norm product
    logic div_start;   // load divider
    logic out_load;    // latch result from metric
  } vdu_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_done;
    logic norm_zero;
    logic root_busy;
    logic div_busy;
  } vdu_sts_t;

  localparam logic [1:0] ROOT_DIFF = 2'd0;
  localparam logic [1:0] ROOT_NX   = 2'd1;
  localparam logic [1:0] ROOT_NY   = 2'd2;

endpackage

[hw/rtl/vdu_if.sv]
// ----------------------------------------------------------------------------
// vdu_if
// Valid/ready channel interfaces for input and result items.
// ----------------------------------------------------------------------------
interface vdu_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] x_elem;
  logic signed [15:0] y_elem;
  modport source (output valid, x_elem, y_elem, input ready);
  modport sink (input valid, x_elem, y_elem, output ready);
endinterface

interface vdu_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [27:0] distance;
  logic zero_norm;
  modport source (output valid, distance, zero_norm, input ready);
  modport sink (input valid, distance, zero_norm, output ready);
endinterface

[hw/rtl/vdu_datapath.sv]
// ----------------------------------------------------------------------------
// vdu_datapath
// Accumulators, shared bit-serial square root, restoring divider, result mux.
// ----------------------------------------------------------------------------
module vdu_datapath
  import vdu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  vdu_cmd_t cmd,
  output vdu_sts_t sts,
  input  logic signed [15:0] x_elem,
  input  logic signed [15:0] y_elem,
  input  logic [1:0] metric,
  input  logic [10:0] vector_length,
  output logic signed [27:0] distance,
  output logic zero_norm
);

  logic [10:0] element_count;
  logic [42:0] diff_square_sum;
  logic signed [41:0] dot_sum;
  logic [40:0] first_norm_sum;
  logic [40:0] second_norm_sum;
  logic [10:0] eff_len;
  logic signed [16:0] d;
  logic [10:0] count_inc;

  // effective length: zero acts as one, clamp to max
  always_comb begin
    eff_len = vector_length;
    if (vector_length == 11'd0) eff_len = 11'd1;
    if (vector_length > 11'(MaxDim)) eff_len = 11'(MaxDim);
    d = 17'(x_elem) - 17'(y_elem);
    count_inc = element_count + 11'd1;
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clear) begin
      element_count <= '0;
      diff_square_sum <= '0;
      dot_sum <= '0;
      first_norm_sum <= '0;
      second_norm_sum <= '0;
    end else if (cmd.acc_en) begin
      element_count <= count_inc;
      diff_square_sum <= diff_square_sum + 43'($unsigned(33'(d) * 33'(d)));
      dot_sum <= dot_sum + 42'(32'(x_elem) * 32'(y_elem));
      first_norm_sum <= first_norm_sum + 41'($unsigned(32'(x_elem) * 32'(x_elem)));
      second_norm_sum <= second_norm_sum + 41'($unsigned(32'(y_elem) * 32'(y_elem)));
    end
  end

  // root unit: one result bit per cycle, 62-bit operand
  logic [61:0] root_rem;
  logic [61:0] root_val;
  logic [61:0] root_bit;
  logic [61:0] root_trial;
  logic [30:0] norm_x;
  logic [61:0] root_op;

  always_comb begin
    case (cmd.root_sel)
      ROOT_NX:  root_op = 62'(first_norm_sum) << 20;
      ROOT_NY:  root_op = 62'(second_norm_sum) << 20;
      default:  root_op = 62'(diff_square_sum) << 2;
    endcase
    root_trial = root_val + root_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_bit <= '0;
    end else if (cmd.root_start) begin
      root_rem <= root_op;
      root_val <= '0;
      root_bit <= 62'h1000000000000000;
    end else if (root_bit != '0) begin
      if (root_rem >= root_trial) begin
        root_rem <= root_rem - root_trial;
        root_val <= (root_val >> 1) + root_bit;
      end else begin
        root_val <= root_val >> 1;
      end
      root_bit <= root_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_save_x) norm_x <= root_val[30:0];
  end

  // norm product, registered
  logic [61:0] prod;
  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= 62'(norm_x) * 62'(root_val[30:0]);
  end

  // restoring divider: 42-bit |dot| / prod, Q.16 quotient
  logic [41:0] mag;
  logic [77:0] div_num;
  logic [62:0] div_rem;
  logic [77:0] div_q;
  logic [6:0] div_cnt;
  logic [62:0] div_shift;
  logic [61:0] divisor;

  always_comb begin
    mag = dot_sum[41] ? 42'(-dot_sum) : 42'(dot_sum);
    div_shift = {div_rem[61:0], div_num[77]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_num <= {mag[41:0], 36'd0};
      div_rem <= '0;
      div_q <= '0;
      div_cnt <= 7'd78;
      divisor <= (prod == '0) ? 62'd1 : prod;
    end else if (div_cnt != '0) begin
      div_num <= div_num << 1;
      if (div_shift >= 63'(divisor)) begin
        div_rem <= div_shift - 63'(divisor);
        div_q <= {div_q[76:0], 1'b1};
      end else begin
        div_rem <= div_shift;
        div_q <= {div_q[76:0], 1'b0};
      end
      div_cnt <= div_cnt - 7'd1;
    end
  end

  // result select and saturation
  logic signed [43:0] ip_t;
  logic signed [43:0] ip_q;
  logic [40:0] cos_q;
  logic signed [43:0] cos_v;
  logic signed [43:0] pick;
  logic signed [27:0] dist_sat;

  always_comb begin
    ip_t = 44'sd1073741824 - 44'(dot_sum) + 44'sd8192;
    ip_q = ip_t >>> 14;
    cos_q = (div_q > 78'(41'h10000000000)) ? 41'h10000000000 : div_q[40:0];
    if (dot_sum[41]) cos_v = 44'sd65536 + 44'(cos_q);
    else cos_v = 44'sd65536 - 44'(cos_q);
    case (metric)
      METRIC_IP:  pick = ip_q;
      METRIC_COS: pick = cos_v;
      default:    pick = 44'($signed({1'b0, root_val[31:0]}));
    endcase
    if (pick > 44'(DIST_MAX)) dist_sat = DIST_MAX;
    else if (pick < 44'(DIST_MIN)) dist_sat = DIST_MIN;
    else dist_sat = pick[27:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (metric == METRIC_COS && sts.norm_zero) begin
        distance <= '0;
        zero_norm <= 1'b1;
      end else begin
        distance <= dist_sat;
        zero_norm <= 1'b0;
      end
    end
  end

  assign sts.count_done = (element_count >= eff_len);
  assign sts.norm_zero = (first_norm_sum == '0) || (second_norm_sum == '0);
  assign sts.root_busy = (root_bit != '0);
  assign sts.div_busy = (div_cnt != '0);

endmodule

[hw/rtl/vdu_ctrl.sv]
// ----------------------------------------------------------------------------
// vdu_ctrl
// Sequencer: accumulate items, run the finishing steps, hold the result.
// ----------------------------------------------------------------------------
module vdu_ctrl
  import vdu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic [1:0] metric,
  input  vdu_sts_t sts,
  output vdu_cmd_t cmd
);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_NY    = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic pend;
  logic pend_next;
  logic out_full;
  logic out_full_next;

  // input is taken while accumulating and the result register can drain
  assign in_ready = (state == S_ACC) && !(out_full && !out_ready);
  assign out_valid = out_full;

  always_comb begin
    cmd = '0;
    state_next = state;
    pend_next = pend;
    out_full_next = out_full && !out_ready;
    case (state)
      S_ACC: begin
        if (in_valid && in_ready) begin
          cmd.acc_en = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.count_done) begin
          state_next = S_ACC;
        end else if (metric == METRIC_IP ||
                     (metric == METRIC_COS && sts.norm_zero)) begin
          state_next = S_OUT;
        end else if (metric == METRIC_COS) begin
          cmd.root_start = 1'b1;
          cmd.root_sel = ROOT_NX;
          pend_next = 1'b1;
          state_next = S_ROOT;
        end else begin
          cmd.root_start = 1'b1;
          cmd.root_sel = ROOT_DIFF;
          pend_next = 1'b0;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (!sts.root_busy) begin
          if (pend) begin
            cmd.root_save_x = 1'b1;
            cmd.root_start = 1'b1;
            cmd.root_sel = ROOT_NY;
            pend_next = 1'b0;
            state_next = S_NY;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_NY: begin
        if (!sts.root_busy) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          if (pend) begin
            state_next = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            pend_next = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!out_full || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.acc_clear = 1'b1;
          out_full_next = 1'b1;
          pend_next = 1'b0;
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      pend <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      pend <= pend_next;
      out_full <= out_full_next;
    end
  end

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_ACC) |-> !in_ready) else $error("input taken while finishing");
  a_load_only_out: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (state == S_OUT)) else $error("result load outside output step");
  a_check_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_en |=> (state == S_CHECK)) else $error("no count check after item");
`endif

endmodule

[hw/rtl/vector_distance_unit.sv]
// ----------------------------------------------------------------------------
// vector_distance_unit
// Streaming L2 / inner product / cosine distance over Q1.15 vector pairs.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in        in   x_elem, y_elem (signed Q1.15)
// out       out  distance (signed, 16 fraction bits), zero_norm
// config    in   cfg_we, cfg_index, cfg_data
//
// Each item is accepted, then its count is checked while input is held. After
// the last item, ip or a cosine zero norm goes to the output step, l2 runs the
// 31-step root and the output step, cosine two roots, the product, the 78-step
// divider and the output step. Reset is synchronous and clears accumulators
// and registers to metric l2, length 128. A result waits in the output register;
// input also stalls while that register is full and not being taken.
module vector_distance_unit
  import vdu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  vdu_in_if.sink in,
  vdu_out_if.source out,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [10:0] cfg_data
);

  logic [1:0] metric;
  logic [10:0] vector_length;
  vdu_cmd_t cmd;
  vdu_sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= METRIC_L2;
      vector_length <= 11'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_METRIC: metric <= cfg_data[1:0];
        REG_LENGTH: vector_length <= cfg_data;
        default: ;
      endcase
    end
  end

  vdu_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .metric(metric), .sts(sts), .cmd(cmd)
  );

  vdu_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .x_elem(in.x_elem), .y_elem(in.y_elem),
    .metric(metric), .vector_length(vector_length),
    .distance(out.distance), .zero_norm(out.zero_norm)
  );

endmodule

[tb/vector_distance_unit_test.sv]
// ----------------------------------------------------------------------------
// vector_distance_unit_test
// Self-checking bench for the vector distance unit. Streams element pairs
// through the input channel and predicts each distance from a local model of
// the accumulators. Results are checked in order as they arrive. Metric and
// length settings are changed between phases, and both channels are idled
// at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_distance_unit_test
  import vdu_pkg::*;
;

  localparam longint CycleLimit = 2000000;
  localparam int DrainCycles = 250;

  typedef struct {
    logic signed [27:0] distance;
    logic zero_norm;
  } dist_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [10:0] cfg_data;

  vdu_in_if in_ch (clk);
  vdu_out_if out_ch (clk);

  vector_distance_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch.sink),
    .out(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // local copy of the block state
  logic [1:0] cur_metric;
  logic [10:0] cur_length;
  int unsigned elem_count;
  bit [63:0] diff_sq_acc;
  longint dot_acc;
  bit [63:0] x_norm_acc;
  bit [63:0] y_norm_acc;

  dist_result_t pending_dist[$];
  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  longint cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor square root, bit by bit
  function automatic bit [63:0] isqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint saturate28(longint v);
    if (v > longint'(DIST_MAX)) return longint'(DIST_MAX);
    if (v < longint'(DIST_MIN)) return longint'(DIST_MIN);
    return v;
  endfunction

  function automatic int unsigned effective_length();
    if (cur_length == 0) return 1;
    if (cur_length > MaxDim) return MaxDim;
    return cur_length;
  endfunction

  // distance of the current accumulators
  function automatic dist_result_t distance_now();
    dist_result_t r;
    longint t;
    longint qs;
    bit [63:0] nx, ny, p, mag, q, rem;
    r.zero_norm = 1'b0;
    if (cur_metric == METRIC_IP) begin
      t = (longint'(1) << 30) - dot_acc + 8192;
      if (t >= 0) qs = t >>> 14;
      else qs = -longint'(($unsigned(-t) + 16383) >> 14);
      r.distance = 28'(saturate28(qs));
    end else if (cur_metric == METRIC_COS) begin
      if (x_norm_acc == 0 || y_norm_acc == 0) begin
        r.distance = '0;
        r.zero_norm = 1'b1;
      end else begin
        nx = isqrt(x_norm_acc << 20);
        ny = isqrt(y_norm_acc << 20);
        p = nx * ny;
        mag = dot_acc < 0 ? -dot_acc : dot_acc;
        if (p == 0) p = 1;
        q = mag / p;
        rem = mag % p;
        for (int i = 0; i < 36; i++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= p) begin
            rem = rem - p;
            q[0] = 1'b1;
          end
        end
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        if (dot_acc < 0) r.distance = 28'(saturate28(65536 + longint'(q)));
        else r.distance = 28'(saturate28(65536 - longint'(q)));
      end
    end else begin
      r.distance = 28'(saturate28(longint'(isqrt(diff_sq_acc << 2))));
    end
    return r;
  endfunction

  function automatic void clear_sums();
    elem_count = 0;
    diff_sq_acc = 0;
    dot_acc = 0;
    x_norm_acc = 0;
    y_norm_acc = 0;
  endfunction

  // fold one accepted pair into the sums, queue a distance at vector end
  function automatic void accumulate_pair(logic signed [15:0] x, logic signed [15:0] y);
    longint xs, ys, d;
    xs = x;
    ys = y;
    d = xs - ys;
    diff_sq_acc += $unsigned(d * d);
    dot_acc += xs * ys;
    x_norm_acc += $unsigned(xs * xs);
    y_norm_acc += $unsigned(ys * ys);
    elem_count++;
    if (elem_count >= effective_length()) begin
      pending_dist.insert(pending_dist.size(), distance_now());
      clear_sums();
    end
  endfunction

  // send one pair and wait for it to be taken
  task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x_elem <= x;
    in_ch.y_elem <= y;
    do @(posedge clk); while (!in_ch.ready);
    accumulate_pair(x, y);
  endtask

  // register write once every result is out and the block has settled
  task automatic write_reg(logic idx, logic [10:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_dist.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_METRIC) cur_metric = val[1:0];
    else cur_length = val;
  endtask

  // result checker and output stalls
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_dist.size() == 0) begin
        $error("unexpected result: distance %0d zero_norm %0d",
               out_ch.distance, out_ch.zero_norm);
        errors++;
      end else begin
        if (out_ch.distance !== pending_dist[0].distance) begin
          $error("distance: expected %0d actual %0d",
                 pending_dist[0].distance, out_ch.distance);
          errors++;
        end
        if (out_ch.zero_norm !== pending_dist[0].zero_norm) begin
          $error("zero_norm: expected %0d actual %0d",
                 pending_dist[0].zero_norm, out_ch.zero_norm);
          errors++;
        end
        void'(pending_dist.pop_front());
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // extremes of the elements under l2, one element per vector
  task automatic test_extremes();
    write_reg(REG_METRIC, 11'(METRIC_L2));
    write_reg(REG_LENGTH, 11'd1);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(16'sd0, 16'sd0);
    send_pair(-16'sd1, 16'sd1);
    send_pair(16'sh5555, -16'sh5556);
  endtask

  task automatic test_inner_product();
    write_reg(REG_METRIC, 11'(METRIC_IP));
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(16'sd1, 16'sd1);
    send_pair(16'sd0, 16'sd0);
  endtask

  // cosine with a zero first norm, a normal pair and a zero second norm
  task automatic test_cosine();
    write_reg(REG_METRIC, 11'(METRIC_COS));
    write_reg(REG_LENGTH, 11'd2);
    send_pair(16'sd0, 16'sd100);
    send_pair(16'sd0, -16'sd5);
    send_pair(16'sd12000, -16'sd32768);
    send_pair(-16'sd32768, 16'sd7);
    send_pair(16'sd32767, 16'sd0);
    send_pair(-16'sd1, 16'sd0);
  endtask

  // metric code 3 and a length of zero
  task automatic test_unused_codes();
    write_reg(REG_METRIC, 11'd3);
    write_reg(REG_LENGTH, 11'd0);
    send_pair(16'sd300, -16'sd300);
    send_pair(-16'sd32768, 16'sd32767);
  endtask

  // shorten the length with a vector part way in
  task automatic test_length_change();
    write_reg(REG_METRIC, 11'(METRIC_IP));
    write_reg(REG_LENGTH, 11'd4);
    send_pair(16'sd1000, 16'sd2000);
    send_pair(-16'sd3000, 16'sd4000);
    send_pair(16'sd5, 16'sd6);
    write_reg(REG_LENGTH, 11'd2);
    send_pair(16'sd7, -16'sd8);
  endtask

  function automatic logic signed [15:0] rand_elem(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return $urandom_range(1) ? -16'sd32768 : 16'sd32767;
      default: return 16'(signed'($urandom_range(64)) - 32);
    endcase
  endfunction

  // random vectors over random settings, with idling phases
  task automatic test_random();
    int len, n, shape, kind;
    logic signed [15:0] x, y;
    int idle_send[4] = '{0, 58, 0, 20};
    int idle_recv[4] = '{0, 0, 58, 20};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_send[ph];
      recv_stall_pct = idle_recv[ph];
      for (int seg = 0; seg < 14; seg++) begin
        write_reg(REG_METRIC, 11'($urandom_range(3)));
        case ($urandom_range(9))
          0: len = 0;
          1: len = $urandom_range(17, 64);
          default: len = $urandom_range(1, 12);
        endcase
        if (ph == 3 && seg == 0) len = 2047;
        write_reg(REG_LENGTH, 11'(len));
        if (len == 0) len = 1;
        if (len > MaxDim) len = MaxDim;
        n = len * $urandom_range(1, len > 16 ? 1 : 5) + $urandom_range(0, 2);
        for (int v = 0; v < n; v++) begin
          if (v % len == 0) begin
            shape = $urandom_range(7);
            kind = $urandom_range(3);
          end
          x = rand_elem(kind);
          y = rand_elem(kind);
          case (shape)
            1: x = 0;
            2: y = 0;
            3: y = x;
            4: y = -x;
            default: ;
          endcase
          send_pair(x, y);
        end
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_METRIC;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.x_elem = '0;
    in_ch.y_elem = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    cycle_count = 0;
    cur_metric = METRIC_L2;
    cur_length = 11'd128;
    clear_sums();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_inner_product();
    test_cosine();
    test_unused_codes();
    test_length_change();
    test_random();

    wait (pending_dist.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/vdu_pkg.sv
hw/rtl/vdu_if.sv
hw/rtl/vdu_datapath.sv
hw/rtl/vdu_ctrl.sv
hw/rtl/vector_distance_unit.sv
tb/vector_distance_unit_test.sv
